// ----- rtl/jtl_pkg.sv -----
// Shared types, codes and character constants for the JSON token lexer.
package jtl_pkg;

  localparam longint unsigned MAX_DOC_LEN = 64'd65536;
  localparam int QUEUE_DEPTH = 4;

  localparam int POS_W  = 17;
  localparam int KIND_W = 4;
  localparam int MAX_TOK = 3;
  localparam int TOKCNT_W = 2;

  // token kinds
  localparam logic [KIND_W-1:0] K_LBRACKET = 4'd0;
  localparam logic [KIND_W-1:0] K_RBRACKET = 4'd1;
  localparam logic [KIND_W-1:0] K_LCURLY   = 4'd2;
  localparam logic [KIND_W-1:0] K_RCURLY   = 4'd3;
  localparam logic [KIND_W-1:0] K_COLON    = 4'd4;
  localparam logic [KIND_W-1:0] K_COMMA    = 4'd5;
  localparam logic [KIND_W-1:0] K_STRING   = 4'd6;
  localparam logic [KIND_W-1:0] K_INT      = 4'd7;
  localparam logic [KIND_W-1:0] K_FLOAT    = 4'd8;
  localparam logic [KIND_W-1:0] K_NULL     = 4'd9;
  localparam logic [KIND_W-1:0] K_UNKNOWN  = 4'd10;
  localparam logic [KIND_W-1:0] K_END      = 4'd11;

  // characters
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_present;
    logic       end_of_doc;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [POS_W-1:0]  token_start;
    logic [POS_W-1:0]  token_length;
    logic              last_of_run;
  } out_item_t;

  // all tokens caused by one input item, oldest in slot 0
  typedef struct packed {
    out_item_t [MAX_TOK-1:0] tok;
    logic [TOKCNT_W-1:0]     cnt;
  } tok_group_t;

  typedef struct packed {
    logic       valid;
    tok_group_t grp;
  } grp_wr_t;

  // letters of the keyword "null"
  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = CH_N;
      2'd1: ch = CH_U;
      default: ch = CH_L;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/jtl_front.sv -----
// Front end: byte-at-a-time lexer that turns each item into a group of tokens.
module jtl_front #(
  parameter longint unsigned MAX_DOC_LEN = jtl_pkg::MAX_DOC_LEN
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  jtl_pkg::in_item_t  item,
  output jtl_pkg::grp_wr_t   wr
);

  localparam int PW = $clog2(MAX_DOC_LEN + 64'd1);
  localparam int OW = jtl_pkg::POS_W;
  localparam logic [PW-1:0] MAXP = PW'(MAX_DOC_LEN);
  localparam logic [PW-1:0] ONE  = PW'(1);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_KEY  = 2'd3;

  localparam int NCAND = 4;

  logic [1:0]    mode_r, mode_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] begin_r, begin_nxt;
  logic [PW-1:0] span_r, span_nxt;
  logic [1:0]    kidx_r, kidx_nxt;
  logic          pt_r, pt_nxt;

  logic                  c_v   [NCAND];
  jtl_pkg::out_item_t    c_tok [NCAND];
  jtl_pkg::tok_group_t   grp;
  logic [1:0]            k;
  logic                  relex;
  logic [7:0]            c;
  logic [PW-1:0]         span_inc;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v >= MAXP) ? MAXP : v + ONE;
  endfunction

  function automatic jtl_pkg::out_item_t mk_tok(input logic [jtl_pkg::KIND_W-1:0] kind,
                                                input logic [PW-1:0] start,
                                                input logic [PW-1:0] len);
    jtl_pkg::out_item_t t;
    t.token_kind   = kind;
    t.token_start  = OW'(start);
    t.token_length = OW'(len);
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  assign c        = item.char_byte;
  assign span_inc = sat_inc(span_r);

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    begin_nxt = begin_r;
    span_nxt  = span_r;
    kidx_nxt  = kidx_r;
    pt_nxt    = pt_r;
    relex     = 1'b0;
    for (int i = 0; i < NCAND; i++) begin
      c_v[i]   = 1'b0;
      c_tok[i] = '0;
    end

    if (item.byte_present) begin
      case (mode_r)
        MODE_STR: begin
          if (c == jtl_pkg::CH_QUOTE) begin
            c_v[0]   = 1'b1;
            c_tok[0] = mk_tok(jtl_pkg::K_STRING, begin_r, span_r);
            mode_nxt = MODE_IDLE;
            span_nxt = '0;
          end else begin
            span_nxt = span_inc;
          end
        end
        MODE_NUM: begin
          if (c inside {[jtl_pkg::CH_0:jtl_pkg::CH_9]}) begin
            span_nxt = span_inc;
          end else if (c == jtl_pkg::CH_POINT && !pt_r) begin
            pt_nxt   = 1'b1;
            span_nxt = span_inc;
          end else begin
            // close the run, then lex the closing byte from idle
            c_v[0]   = 1'b1;
            c_tok[0] = mk_tok((c == jtl_pkg::CH_POINT) ? jtl_pkg::K_UNKNOWN :
                              (pt_r ? jtl_pkg::K_FLOAT : jtl_pkg::K_INT),
                              begin_r, span_r);
            mode_nxt = MODE_IDLE;
            span_nxt = '0;
            pt_nxt   = 1'b0;
            relex    = 1'b1;
          end
        end
        MODE_KEY: begin
          span_nxt = span_inc;
          if (c == jtl_pkg::kw_char(kidx_r)) begin
            if (kidx_r == 2'd3) begin
              c_v[0]   = 1'b1;
              c_tok[0] = mk_tok(jtl_pkg::K_NULL, begin_r, span_inc);
              mode_nxt = MODE_IDLE;
              span_nxt = '0;
              kidx_nxt = '0;
            end else begin
              kidx_nxt = kidx_r + 2'd1;
            end
          end else begin
            // mismatch: offending byte is part of the unknown token
            c_v[0]   = 1'b1;
            c_tok[0] = mk_tok(jtl_pkg::K_UNKNOWN, begin_r, span_inc);
            mode_nxt = MODE_IDLE;
            span_nxt = '0;
            kidx_nxt = '0;
          end
        end
        default: relex = 1'b1;
      endcase

      if (relex) begin
        if (c inside {jtl_pkg::CH_SP, jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR}) begin
          // skip whitespace
        end else begin
          case (c)
            jtl_pkg::CH_LBRACK: begin
              c_v[1] = 1'b1; c_tok[1] = mk_tok(jtl_pkg::K_LBRACKET, pos_r, ONE);
            end
            jtl_pkg::CH_RBRACK: begin
              c_v[1] = 1'b1; c_tok[1] = mk_tok(jtl_pkg::K_RBRACKET, pos_r, ONE);
            end
            jtl_pkg::CH_LCURLY: begin
              c_v[1] = 1'b1; c_tok[1] = mk_tok(jtl_pkg::K_LCURLY, pos_r, ONE);
            end
            jtl_pkg::CH_RCURLY: begin
              c_v[1] = 1'b1; c_tok[1] = mk_tok(jtl_pkg::K_RCURLY, pos_r, ONE);
            end
            jtl_pkg::CH_COLON: begin
              c_v[1] = 1'b1; c_tok[1] = mk_tok(jtl_pkg::K_COLON, pos_r, ONE);
            end
            jtl_pkg::CH_COMMA: begin
              c_v[1] = 1'b1; c_tok[1] = mk_tok(jtl_pkg::K_COMMA, pos_r, ONE);
            end
            jtl_pkg::CH_QUOTE: begin
              mode_nxt  = MODE_STR;
              begin_nxt = sat_inc(pos_r);
              span_nxt  = '0;
            end
            jtl_pkg::CH_N: begin
              mode_nxt  = MODE_KEY;
              begin_nxt = pos_r;
              span_nxt  = ONE;
              kidx_nxt  = 2'd1;
            end
            default: begin
              if (c inside {[jtl_pkg::CH_0:jtl_pkg::CH_9]}) begin
                mode_nxt  = MODE_NUM;
                begin_nxt = pos_r;
                span_nxt  = ONE;
                pt_nxt    = 1'b0;
              end else begin
                c_v[1]   = 1'b1;
                c_tok[1] = mk_tok(jtl_pkg::K_UNKNOWN, pos_r, ONE);
              end
            end
          endcase
        end
      end
      pos_nxt = sat_inc(pos_r);
    end

    if (item.end_of_doc) begin
      // flush whatever is pending, then the end token
      case (mode_nxt)
        MODE_STR: begin
          c_v[2] = 1'b1; c_tok[2] = mk_tok(jtl_pkg::K_STRING, begin_nxt, span_nxt);
        end
        MODE_NUM: begin
          c_v[2]   = 1'b1;
          c_tok[2] = mk_tok(pt_nxt ? jtl_pkg::K_FLOAT : jtl_pkg::K_INT, begin_nxt, span_nxt);
        end
        MODE_KEY: begin
          c_v[2] = 1'b1; c_tok[2] = mk_tok(jtl_pkg::K_UNKNOWN, begin_nxt, span_nxt);
        end
        default: ;
      endcase
      c_v[3]    = 1'b1;
      c_tok[3]  = mk_tok(jtl_pkg::K_END, pos_nxt, ONE);
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      begin_nxt = '0;
      span_nxt  = '0;
      kidx_nxt  = '0;
      pt_nxt    = 1'b0;
    end
  end

  // pack the candidates into consecutive slots
  always_comb begin
    grp = '0;
    k   = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (c_v[i] && k != 2'd3) begin
        grp.tok[k] = c_tok[i];
        k = k + 2'd1;
      end
    end
    if (k != 2'd0) grp.tok[k - 2'd1].last_of_run = 1'b1;
    grp.cnt = k;
  end

  assign wr.valid = take && (k != 2'd0);
  assign wr.grp   = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      begin_r <= '0;
      span_r  <= '0;
      kidx_r  <= '0;
      pt_r    <= 1'b0;
    end else if (take) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      span_r  <= span_nxt;
      kidx_r  <= kidx_nxt;
      pt_r    <= pt_nxt;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE |-> span_r == '0 && kidx_r == 2'd0 && !pt_r)
    else $error("idle lexer holds leftover token state");

  a_key_index: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_KEY |-> kidx_r != 2'd0 && span_r != '0)
    else $error("keyword match without a started keyword");

endmodule

// ----- rtl/jtl_back.sv -----
// Back end: queue of token groups, drained one token per pop.
module jtl_back #(
  parameter int DEPTH = jtl_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  jtl_pkg::grp_wr_t    wr,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output jtl_pkg::out_item_t  item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  jtl_pkg::tok_group_t grp_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [jtl_pkg::TOKCNT_W-1:0] slot_r, slot_nxt;

  jtl_pkg::tok_group_t head;
  logic do_pop, grp_done;

  assign head  = grp_r[rp_r];
  assign item  = head.tok[slot_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));

  assign do_pop   = pop && !empty;
  assign grp_done = do_pop && (slot_r == head.cnt - 2'd1);

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    cnt_nxt  = cnt_r;
    slot_nxt = slot_r;
    if (wr.valid) wp_nxt = (wp_r == LAST) ? '0 : wp_r + AW'(1);
    if (do_pop) begin
      if (grp_done) begin
        rp_nxt   = (rp_r == LAST) ? '0 : rp_r + AW'(1);
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + 2'd1;
      end
    end
    if (wr.valid && !grp_done) cnt_nxt = cnt_r + CW'(1);
    else if (!wr.valid && grp_done) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid) grp_r[wp_r] <= wr.grp;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr.valid |-> !full)
    else $error("token group written into a full queue");

  a_head_slot: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> head.cnt != 2'd0 && slot_r < head.cnt)
    else $error("read slot outside the head group");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- rtl/json_token_lexer_unit.sv -----
// Top level of the JSON token lexer: lexing front end and token queue.
//
//  channel   dir  transfer when            payload
//  input     in   push && !full            in_item  (char_byte, byte_present, end_of_doc)
//  result    out  pop && !empty            out_item (token_kind, token_start,
//                                                    token_length, last_of_run)
//
// Cycles: one input item per cycle while full is low; the lexer finishes an item
//   in the cycle it is taken and writes its tokens (zero to three) as one group into
//   the queue. Tokens leave one per cycle while pop is high, so the queue drain
//   rate sets the sustained rate when items produce more than one token each.
// Stalls: full rises when QUEUE_DEPTH token groups wait; items with no token
//   take no queue entry. The two sides stall independently.
// Reset: synchronous, active low; clears lexer state and queue pointers, no
//   clearing pass.
module json_token_lexer_unit #(
  parameter longint unsigned MAX_DOC_LEN = jtl_pkg::MAX_DOC_LEN, // 16 .. 2^17 - 1
  parameter int              QUEUE_DEPTH = jtl_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  jtl_pkg::in_item_t   in_item,
  output logic                empty,
  input  logic                pop,
  output jtl_pkg::out_item_t  out_item
);

  jtl_pkg::grp_wr_t grp_wr;
  logic             take;

  // accept an item only when its token group is sure to fit
  assign take = push && !full;

  jtl_front #(
    .MAX_DOC_LEN(MAX_DOC_LEN)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .take (take),
    .item (in_item),
    .wr   (grp_wr)
  );

  // hold token groups until the consumer pops them, one token per transfer
  jtl_back #(
    .DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (grp_wr),
    .pop  (pop),
    .full (full),
    .empty(empty),
    .item (out_item)
  );

endmodule
